// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Field widths of one beat.
    localparam int PRIO_W = 16;
    localparam int TAG_W  = 32;
    localparam int STAT_W = 2;

    // Default number of cells in the chain.
    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    // One stored entry.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } spq_entry_t;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic       ins;
        logic       rem;
        spq_entry_t new_entry;
    } spq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake           Payload
// -------  ------------------  -----------------------------------
// in       in_valid/in_ready   action, priority_req, tag
// out      out_valid/out_ready status, out_tag, out_priority
//
// For each insert that fits, all cells compare against the new priority in
// parallel and those from the insertion point shift by one place; a remove
// shifts every cell toward the head. The result lands in the output register
// on the next edge. One beat per cycle is sustained while out_ready is high.
// Reset clears only the fill count and the output valid flag. A stalled output
// holds its beat; a new request is taken in the same cycle as the waiting result leaves.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              action,
    input  wire logic [PRIO_W-1:0] priority_req,
    input  wire logic [TAG_W-1:0]  tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [TAG_W-1:0]       out_tag,
    output logic [PRIO_W-1:0]      out_priority
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [TAG_W-1:0]  out_tag_next;
    logic [PRIO_W-1:0] out_priority_reg;
    logic [PRIO_W-1:0] out_priority_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    spq_cmd_t   cmd;
    logic       take [DEPTH];
    spq_entry_t cells [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = count_reg == CNT_W'(DEPTH);
    assign is_empty = count_reg == '0;

    // Command seen by the whole chain this cycle.
    always_comb
    begin
        cmd.ins            = accept && (action == ACT_INSERT) && !is_full;
        cmd.rem            = accept && (action == ACT_REMOVE) && !is_empty;
        cmd.new_entry.prio = priority_req;
        cmd.new_entry.tag  = tag;
    end

    // The row of cells, each wired to its neighbors; the head's left is the new entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       left_take;
        spq_entry_t left_entry;
        spq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_take  = 1'b0;
            assign left_entry = cmd.new_entry;
        end
        else
        begin : g_body
            assign left_take  = take[i-1];
            assign left_entry = cells[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cells[i];
        end
        else
        begin : g_mid
            assign right_entry = cells[i+1];
        end

        spq_cell #(
            .INDEX(i),
            .CNT_W(CNT_W)
        ) u_cell (
            .clk        (clk),
            .count      (count_reg),
            .cmd        (cmd),
            .left_take  (left_take),
            .left_entry (left_entry),
            .right_entry(right_entry),
            .take       (take[i]),
            .entry      (cells[i])
        );
    end

    // Fill count and the result of the accepted beat.
    always_comb
    begin
        count_next        = count_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        out_tag_next      = out_tag_reg;
        out_priority_next = out_priority_reg;
        if (accept)
        begin
            out_valid_next    = 1'b1;
            out_tag_next      = '0;
            out_priority_next = '0;
            unique case (action)
                ACT_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        status_next = STAT_INSERTED;
                        count_next  = count_reg + 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        status_next       = STAT_REMOVED;
                        out_tag_next      = cells[0].tag;
                        out_priority_next = cells[0].prio;
                        count_next        = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = STAT_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        out_tag_reg      <= out_tag_next;
        out_priority_reg <= out_priority_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_priority_reg;

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // With two or more entries stored, the head cell holds a priority no lower than the next one.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cells[0].prio >= cells[1].prio))
        else $error("head of queue out of order");

    // An insert into a full queue reports full on the next beat.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_INSERT) && is_full)
        |=> (out_valid && (status == STAT_FULL) && $stable(count_reg)))
        else $error("insert into full queue not flagged");

    // A remove from an empty queue reports empty on the next beat.
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_REMOVE) && is_empty)
        |=> (out_valid && (status == STAT_EMPTY)))
        else $error("remove from empty queue not flagged");

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire logic [CNT_W-1:0] count,
    input  wire spq_cmd_t         cmd,
    input  wire logic             left_take,
    input  wire spq_entry_t       left_entry,
    input  wire spq_entry_t       right_entry,
    output logic                  take,
    output spq_entry_t            entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    logic       occupied;

    // A cell is in use when its position lies below the fill count.
    assign occupied = CNT_W'(INDEX) < count;

    // The new entry belongs at or before this cell when this cell is free
    // or holds a strictly lower priority; equal priorities stay ahead.
    assign take = !occupied || (entry_reg.prio < cmd.new_entry.prio);

    // Insert shifts toward the tail from the insertion point; remove shifts
    // everything one place toward the head.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (take && !left_take)
            begin
                entry_next = cmd.new_entry;
            end
            else if (take)
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
